// ----- design/int64_divide_modulo_defines.svh -----
// Assertion macros shared by the divide/modulo RTL.
// No dependencies; included by files that carry assertions.
`ifndef INT64_DIVIDE_MODULO_DEFINES_SVH
`define INT64_DIVIDE_MODULO_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define IDM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("idm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define IDM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("idm: next-cycle check failed");

`endif

// ----- design/idm_pkg.sv -----
// Package for the 64-bit divide/modulo pipeline: operation codes and
// the control word that travels beside the data. No dependencies.
package idm_pkg;

    // Operation codes on the operation field
    typedef enum logic [1:0] {
        OP_UDIV = 2'd0,
        OP_UREM = 2'd1,
        OP_SDIV = 2'd2,
        OP_SREM = 2'd3
    } idm_op_t;

    // Control word carried stage to stage
    typedef struct packed {
        logic    valid;
        idm_op_t op;
        logic    num_neg;
        logic    den_neg;
        logic    den_zero;
    } idm_ctrl_t;

endpackage

// ----- design/idm_prep.sv -----
// Entry stage: masks the operands to the data width and takes absolute
// values for signed operations. Depends on idm_pkg.
module idm_prep #(
    parameter int W = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [63:0]           dividend,
    input  logic [63:0]           divisor,
    input  logic [1:0]            operation,
    output idm_pkg::idm_ctrl_t    ctrl_out,
    output logic [W-1:0]          num_out,
    output logic [W-1:0]          den_out
);

    logic [W-1:0]       num_raw;
    logic [W-1:0]       den_raw;
    logic               is_signed;
    idm_pkg::idm_ctrl_t ctrl_next;
    idm_pkg::idm_ctrl_t ctrl_reg;
    logic [W-1:0]       num_next;
    logic [W-1:0]       num_reg;
    logic [W-1:0]       den_next;
    logic [W-1:0]       den_reg;

    // Sign handling: negate negative operands of signed operations
    always_comb begin
        num_raw   = dividend[W-1:0];
        den_raw   = divisor[W-1:0];
        is_signed = (idm_pkg::idm_op_t'(operation) == idm_pkg::OP_SDIV) ||
                    (idm_pkg::idm_op_t'(operation) == idm_pkg::OP_SREM);
        ctrl_next.valid    = in_valid;
        ctrl_next.op       = idm_pkg::idm_op_t'(operation);
        ctrl_next.num_neg  = is_signed && num_raw[W-1];
        ctrl_next.den_neg  = is_signed && den_raw[W-1];
        ctrl_next.den_zero = (den_raw == '0);
        num_next = ctrl_next.num_neg ? (W'(0) - num_raw) : num_raw;
        den_next = ctrl_next.den_neg ? (W'(0) - den_raw) : den_raw;
    end

    // Control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_next;
        end
    end

    // Operand registers
    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign num_out  = num_reg;
    assign den_out  = den_reg;

endmodule

// ----- design/idm_step.sv -----
// One restoring divide step: shifts in the next dividend bit, trial
// subtracts the divisor and keeps one quotient bit. Depends on idm_pkg.
module idm_step #(
    parameter int W = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  idm_pkg::idm_ctrl_t    ctrl_in,
    input  logic [W-1:0]          rem_in,
    input  logic [W-1:0]          nq_in,
    input  logic [W-1:0]          den_in,
    output idm_pkg::idm_ctrl_t    ctrl_out,
    output logic [W-1:0]          rem_out,
    output logic [W-1:0]          nq_out,
    output logic [W-1:0]          den_out
);

    logic [W:0]         trial;
    logic [W:0]         diff;
    logic               qbit;
    logic [W-1:0]       rem_next;
    logic [W-1:0]       nq_next;
    idm_pkg::idm_ctrl_t ctrl_reg;
    logic [W-1:0]       rem_reg;
    logic [W-1:0]       nq_reg;
    logic [W-1:0]       den_reg;

    // Trial subtract; top bit of the difference is the borrow
    // nq holds unused dividend bits at the top, quotient bits at the bottom
    always_comb begin
        trial    = {rem_in, nq_in[W-1]};
        diff     = trial - {1'b0, den_in};
        qbit     = !diff[W];
        rem_next = qbit ? diff[W-1:0] : trial[W-1:0];
        nq_next  = {nq_in[W-2:0], qbit};
    end

    // Control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_in;
        end
    end

    // Data registers
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
            den_reg <= den_in;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign nq_out   = nq_reg;
    assign den_out  = den_reg;

endmodule

// ----- design/idm_post.sv -----
// Final stage: picks quotient or remainder, restores the sign and
// forces zero on a zero divisor. Depends on idm_pkg.
module idm_post #(
    parameter int W = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  idm_pkg::idm_ctrl_t    ctrl_in,
    input  logic [W-1:0]          quo_in,
    input  logic [W-1:0]          rem_in,
    output logic                  valid_out,
    output logic [W-1:0]          result_out
);

    logic [W-1:0] res_next;
    logic [W-1:0] res_reg;
    logic         valid_reg;

    // Select and sign-correct
    always_comb begin
        case (ctrl_in.op)
            idm_pkg::OP_UDIV: res_next = quo_in;
            idm_pkg::OP_UREM: res_next = rem_in;
            idm_pkg::OP_SDIV: res_next = (ctrl_in.num_neg != ctrl_in.den_neg) ?
                                         (W'(0) - quo_in) : quo_in;
            idm_pkg::OP_SREM: res_next = ctrl_in.num_neg ? (W'(0) - rem_in) : rem_in;
            default:          res_next = quo_in;
        endcase
        if (ctrl_in.den_zero) begin
            res_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctrl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign valid_out  = valid_reg;
    assign result_out = res_reg;

endmodule

// ----- design/int64_divide_modulo.sv -----
// Top level of the pipelined integer divide/modulo unit.
// Depends on idm_pkg, idm_prep, idm_step, idm_post and the assertion header.
//
//  channel  direction  handshake           word
//  s_       in         s_valid / s_ready   s_dividend, s_divisor, s_operation
//  m_       out        m_valid / m_ready   m_result
//
// One word enters per cycle when s_ready is high. Each word passes an operand
// stage, DATA_WIDTH restoring steps (one quotient bit each), a sign stage and
// the output register. The per-step trial subtract of DATA_WIDTH+1 bits sets
// the cycle time. Reset (aresetn low, synchronous) clears all valid bits.
// The pipe stalls as a whole only when the output register holds an untaken
// word and the last stage also holds one; bubbles let new words enter.
`include "int64_divide_modulo_defines.svh"

module int64_divide_modulo #(
    parameter int DATA_WIDTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_dividend,
    input  logic [63:0] s_divisor,
    input  logic [1:0]  s_operation,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result
);

    localparam int W = DATA_WIDTH;

    idm_pkg::idm_ctrl_t       ctrl   [W+1];
    logic [W-1:0]             rem    [W+1];
    logic [W-1:0]             nq     [W+1];
    logic [W-1:0]             den    [W+1];
    logic                     pipe_en;
    logic                     post_valid;
    logic [W-1:0]             post_result;
    logic                     out_load;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [W-1:0]             out_data_reg;

    // Stall only when the last stage cannot drain into the output register
    assign pipe_en  = !(post_valid && out_valid_reg && !m_ready);
    assign s_ready  = pipe_en;
    assign out_load = !out_valid_reg || m_ready;

    // Operand stage
    idm_prep #(.W(W)) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_valid),
        .dividend  (s_dividend),
        .divisor   (s_divisor),
        .operation (s_operation),
        .ctrl_out  (ctrl[0]),
        .num_out   (nq[0]),
        .den_out   (den[0])
    );
    assign rem[0] = '0;

    // Restoring steps, top quotient bit first
    for (genvar i = 0; i < W; i++) begin : g_step
        idm_step #(.W(W)) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (pipe_en),
            .ctrl_in  (ctrl[i]),
            .rem_in   (rem[i]),
            .nq_in    (nq[i]),
            .den_in   (den[i]),
            .ctrl_out (ctrl[i+1]),
            .rem_out  (rem[i+1]),
            .nq_out   (nq[i+1]),
            .den_out  (den[i+1])
        );
    end

    // Sign and select stage
    idm_post #(.W(W)) u_post (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (pipe_en),
        .ctrl_in    (ctrl[W]),
        .quo_in     (nq[W]),
        .rem_in     (rem[W]),
        .valid_out  (post_valid),
        .result_out (post_result)
    );

    // Output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = post_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= post_result;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = 64'(out_data_reg);

    // Assertions
    `IDM_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, ctrl[0].valid)
    `IDM_ASSERT_NOW(a_full_stall, aclk, aresetn, post_valid && out_valid_reg && !m_ready, !s_ready)
    `IDM_ASSERT_NOW(a_upper_zero, aclk, aresetn, m_valid, (m_result >> DATA_WIDTH) == 64'd0)

endmodule
